// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/srr_pkg.sv =====
package srr_pkg;

  localparam int SEQ_NUM_W   = 8;
  localparam int PAYLOAD_W   = 64;
  localparam int ACK_NUM_W   = 8;

  localparam int DEF_WINDOW       = 8;
  localparam int DEF_SEQ_BITS     = 8;
  localparam int DEF_PAYLOAD_BITS = 64;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic sel_ack;
  } srr_cmd_t;

  typedef struct packed {
    logic in_win;
    logic hit;
    logic cur_valid;
  } srr_sts_t;

endpackage

// ===== rtl/core/srr_if.sv =====
interface srr_pkt_if import srr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SEQ_NUM_W-1:0] seq_num;
  logic [PAYLOAD_W-1:0] payload_word;

  modport source (output valid, output seq_num, output payload_word, input ready);
  modport sink   (input valid, input seq_num, input payload_word, output ready);
endinterface

interface srr_res_if import srr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ACK_NUM_W-1:0] ack_num;
  logic [PAYLOAD_W-1:0] data_word;
  logic                 last;

  modport source (output valid, output kind, output ack_num, output data_word,
                  output last, input ready);
  modport sink   (input valid, input kind, input ack_num, input data_word,
                  input last, output ready);
endinterface

// ===== rtl/core/srr_ctrl.sv =====
module srr_ctrl import srr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  srr_sts_t sts_i,
  output srr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DLV,
    S_ACK
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EVAL;
            in_ready_q <= 1'b0;
          end
        end
        S_EVAL: begin
          if (sts_i.in_win && sts_i.hit) begin
            state_q <= S_READ;
          end else begin
            state_q     <= S_ACK;
            out_valid_q <= 1'b1;
            kind_q      <= 1'b1;
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          if (sts_i.cur_valid) begin
            state_q <= S_DLV;
            kind_q  <= 1'b0;
          end else begin
            state_q <= S_ACK;
            kind_q  <= 1'b1;
          end
        end
        S_DLV: begin
          if (out_ready_i) begin
            state_q     <= S_READ;
            out_valid_q <= 1'b0;
          end
        end
        S_ACK: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // A slot is drained only while the scan finds it valid; the scan stops otherwise.
  assign cmd_o.load    = in_valid_i && in_ready_q;
  assign cmd_o.eval    = (state_q == S_EVAL);
  assign cmd_o.step    = (state_q == S_READ) && sts_i.cur_valid;
  assign cmd_o.sel_ack = kind_q;

endmodule

// ===== rtl/core/srr_dpath.sv =====
module srr_dpath import srr_pkg::*; #(
  parameter int WINDOW       = DEF_WINDOW,
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srr_cmd_t             cmd_i,
  output srr_sts_t             sts_o,
  input  logic [SEQ_NUM_W-1:0] seq_num_i,
  input  logic [PAYLOAD_W-1:0] payload_word_i,
  output logic                 kind_o,
  output logic [ACK_NUM_W-1:0] ack_num_o,
  output logic [PAYLOAD_W-1:0] data_word_o,
  output logic                 last_o
);

  localparam int IDXW = $clog2(WINDOW);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(WINDOW - 1);

  logic [SEQ_BITS-1:0]     seq_q;
  logic [PAYLOAD_BITS-1:0] word_q;
  logic [SEQ_BITS-1:0]     exp_q;
  logic [IDXW-1:0]         exp_idx_q;
  logic [WINDOW-1:0]       valid_q;
  logic [PAYLOAD_BITS-1:0] slot_mem_q [WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_q;

  logic [SEQ_BITS+SEQ_NUM_W-1:0]  seq_ext;
  logic [SEQ_BITS-1:0]            seq_in;
  logic [SEQ_BITS-1:0]            offset;
  logic [IDXW:0]                  idx_sum;
  logic [IDXW:0]                  idx_red;
  logic [IDXW-1:0]                wr_idx;
  logic [SEQ_BITS+ACK_NUM_W-1:0]  ack_ext;
  logic [PAYLOAD_BITS+PAYLOAD_W-1:0] data_ext;

  assign seq_ext = {{SEQ_BITS{1'b0}}, seq_num_i};
  assign seq_in  = seq_ext[SEQ_BITS-1:0];

  assign offset       = seq_q - exp_q;
  assign sts_o.in_win = ({{(32 - SEQ_BITS){1'b0}}, offset} < 32'(WINDOW));
  assign sts_o.hit    = (offset == '0);
  assign sts_o.cur_valid = valid_q[exp_idx_q];

  // Ring slot of seq_q, derived from the slot of the expected number. When the
  // number space wrapped inside the window, seq_q is below WINDOW and is its own slot.
  assign idx_sum = (IDXW+1)'(exp_idx_q) + (IDXW+1)'(offset);
  assign idx_red = (idx_sum >= (IDXW+1)'(WINDOW)) ? idx_sum - (IDXW+1)'(WINDOW) : idx_sum;
  assign wr_idx  = (seq_q < exp_q) ? IDXW'(seq_q) : idx_red[IDXW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seq_q  <= seq_in;
      word_q <= payload_word_i[PAYLOAD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && sts_o.in_win) begin
      slot_mem_q[wr_idx] <= word_q;
    end
    if (cmd_i.step) begin
      rd_q <= slot_mem_q[exp_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      exp_q     <= '0;
      exp_idx_q <= '0;
    end else begin
      if (cmd_i.eval && sts_o.in_win) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.step) begin
        valid_q[exp_idx_q] <= 1'b0;
        exp_q              <= exp_q + 1'b1;
        // The slot index restarts at the end of the ring and whenever the expected number wraps to zero.
        if (exp_q == '1 || exp_idx_q == IDX_LAST) begin
          exp_idx_q <= '0;
        end else begin
          exp_idx_q <= exp_idx_q + 1'b1;
        end
      end
    end
  end

  assign ack_ext  = {{ACK_NUM_W{1'b0}}, seq_q};
  assign data_ext = {{PAYLOAD_W{1'b0}}, rd_q};

  assign kind_o      = cmd_i.sel_ack;
  assign last_o      = cmd_i.sel_ack;
  assign ack_num_o   = cmd_i.sel_ack ? ack_ext[ACK_NUM_W-1:0] : '0;
  assign data_word_o = cmd_i.sel_ack ? '0 : data_ext[PAYLOAD_W-1:0];

endmodule

// ===== rtl/core/selective_repeat_receiver_top.sv =====
// Selective-repeat receiver.
// Packets enter on pkt_i (seq_num, payload_word); results leave on res_o
// (kind, ack_num, data_word, last), both valid/ready channels where a beat
// moves when valid and ready are high at a rising edge.
// A packet whose number falls inside the receive window is stored in its ring
// slot. A packet carrying the expected number then releases the run of
// consecutive stored words, one delivery beat each (kind 0, in order). Every
// packet ends with one acknowledgement beat (kind 1, last 1) with its number.
// One packet is handled at a time. A packet that releases nothing goes from the
// evaluation state straight to its ack beat; a packet that releases words
// alternates a registered slot read and a delivery beat for each word, then
// gives its ack beat. Delivery is paced by the controller stepping through the
// slot memory, one registered read per delivered word.
// A stalled res_o holds the current beat and the block takes no packet until
// the ack beat has gone. Reset clears all slot valid bits and the expected
// number; the slot memory itself is not cleared and needs no sweep.
module selective_repeat_receiver_top import srr_pkg::*; #(
  parameter int WINDOW       = DEF_WINDOW,
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  srr_pkt_if.sink   pkt_i,
  srr_res_if.source res_o
);

  `include "assert_macros.svh"

  srr_cmd_t cmd;
  srr_sts_t sts;

  srr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_i.valid),
    .in_ready_o  (pkt_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srr_dpath #(
    .WINDOW       (WINDOW),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .seq_num_i      (pkt_i.seq_num),
    .payload_word_i (pkt_i.payload_word),
    .kind_o         (res_o.kind),
    .ack_num_o      (res_o.ack_num),
    .data_word_o    (res_o.data_word),
    .last_o         (res_o.last)
  );

  `ASSERT_STD(a_no_accept_while_busy, pkt_i.ready |-> !res_o.valid, "packet taken while busy")
  `ASSERT_STD(a_step_needs_valid, cmd.step |-> sts.cur_valid, "drained an empty slot")
  `ASSERT_STD(a_hit_delivers, (cmd.eval && sts.hit) |=> sts.cur_valid, "expected slot empty")
  `ASSERT_STD(a_delivery_not_last, (res_o.valid && !res_o.kind) |-> !pkt_i.ready, "delivery beside packet")

endmodule
